// File: rtl/pctd_pkg.sv
package pctd_pkg;

   localparam int MAX_NODES_DEFAULT = 1024;

   localparam int OP_W       = 2;
   localparam int CODE_W     = 32;
   localparam int CODE_IDX_W = $clog2(CODE_W);
   localparam int LENGTH_W   = 6;
   localparam int SYMBOL_W   = 8;
   localparam int BYTE_W     = 8;
   localparam int BIT_CNT_W  = $clog2(BYTE_W + 1);
   localparam int COUNT_W    = 32;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_LOAD   = 2'd1,
      OP_DECODE = 2'd2
   } op_type;

   // One request from the tree walker to the result buffer.
   typedef struct packed {
      logic                emit;
      logic                flush;
      logic [SYMBOL_W-1:0] symbol;
      logic                done;
      logic                overflow;
   } push_type;

endpackage

// File: rtl/pctd_node_mem.sv
module pctd_node_mem #(
   parameter int MAX_NODES = pctd_pkg::MAX_NODES_DEFAULT
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [$clog2(MAX_NODES)-1:0]                 wr_addr,
   input  logic [2*$clog2(MAX_NODES)+pctd_pkg::SYMBOL_W-1:0] wr_data,
   input  logic                                         rd_en,
   input  logic [$clog2(MAX_NODES)-1:0]                 rd_addr,
   output logic [2*$clog2(MAX_NODES)+pctd_pkg::SYMBOL_W-1:0] rd_data
);

   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int WORD_W = 2 * NODE_W + pctd_pkg::SYMBOL_W;

   logic [WORD_W-1:0] node_mem_ff [MAX_NODES];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= node_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/pctd_rsp_buf.sv
module pctd_rsp_buf (
   input  logic                          clock,
   input  logic                          reset,
   input  pctd_pkg::push_type            push,
   output logic                          push_ok,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pctd_pkg::SYMBOL_W-1:0] rsp_out_symbol,
   output logic                          rsp_last_of_run,
   output logic                          rsp_stream_done,
   output logic                          rsp_table_overflow
);

   // A decoded symbol waits in the pending stage until the next one arrives or the
   // byte ends, which is when it is known whether it closes the byte's run.
   logic                          pend_valid_ff, pend_valid_in;
   logic [pctd_pkg::SYMBOL_W-1:0] pend_sym_ff, pend_sym_in;
   logic                          pend_done_ff, pend_done_in;
   logic                          pend_ovf_ff, pend_ovf_in;

   logic                          out_valid_ff, out_valid_in;
   logic [pctd_pkg::SYMBOL_W-1:0] out_sym_ff, out_sym_in;
   logic                          out_last_ff, out_last_in;
   logic                          out_done_ff, out_done_in;
   logic                          out_ovf_ff, out_ovf_in;

   logic can_push;
   logic fire;
   logic move;

   always_comb begin
      can_push = !out_valid_ff || !rsp_stall;
      push_ok  = !pend_valid_ff || can_push;
      fire     = (push.emit || push.flush) && push_ok;
      move     = fire && pend_valid_ff;

      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      pend_done_in  = pend_done_ff;
      pend_ovf_in   = pend_ovf_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_sym_in    = out_sym_ff;
      out_last_in   = out_last_ff;
      out_done_in   = out_done_ff;
      out_ovf_in    = out_ovf_ff;

      if (move) begin
         out_valid_in = 1'b1;
         out_sym_in   = pend_sym_ff;
         out_last_in  = push.flush;
         out_done_in  = pend_done_ff;
         out_ovf_in   = pend_ovf_ff;
      end

      if (fire && push.emit) begin
         pend_valid_in = 1'b1;
         pend_sym_in   = push.symbol;
         pend_done_in  = push.done;
         pend_ovf_in   = push.overflow;
      end else if (fire && push.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_sym_ff  <= pend_sym_in;
      pend_done_ff <= pend_done_in;
      pend_ovf_ff  <= pend_ovf_in;
      out_sym_ff   <= out_sym_in;
      out_last_ff  <= out_last_in;
      out_done_ff  <= out_done_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_symbol     = out_sym_ff;
   assign rsp_last_of_run    = out_last_ff;
   assign rsp_stream_done    = out_done_ff;
   assign rsp_table_overflow = out_ovf_ff;

endmodule

// File: rtl/prefix_code_tree_decoder.sv
// Prefix-code decoder that walks a binary code tree held in a node memory with one
// write port and one read port. It takes a new transaction only when idle. A clear is
// done in the idle state. A load takes one step per code bit that follows an existing
// node, an evaluate step and a link step per bit that allocates a new node, and a last
// step to store the symbol and return to idle. A decode takes eight bit steps, plus an
// emit step for each symbol emitted inside the byte (the bit is then retried from the
// root); then ST_DC_EVAL checks the end of the byte and ST_DC_FIN closes the run and
// returns to idle. The walk also waits while a result is stalled. A byte cut short by
// the configured total skips its remaining bits, and a decode arriving after the total
// is reached is taken and leaves the block idle. The step time is set by the node memory:
// every step reads the next node, and the registered read data feeds the following step.
// Allocation is tracked by a free-node counter, so there is no clearing pass after reset
// or clear. Results stall only the tree walk; a new transaction is taken while the last
// result still waits in the output register.
module prefix_code_tree_decoder #(
   parameter int MAX_NODES = pctd_pkg::MAX_NODES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pctd_pkg::OP_W-1:0]     req_operation,
   input  logic [pctd_pkg::CODE_W-1:0]   req_code_word,
   input  logic [pctd_pkg::LENGTH_W-1:0] req_code_length,
   input  logic [pctd_pkg::SYMBOL_W-1:0] req_code_symbol,
   input  logic [pctd_pkg::BYTE_W-1:0]   req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pctd_pkg::SYMBOL_W-1:0] rsp_out_symbol,
   output logic                          rsp_last_of_run,
   output logic                          rsp_stream_done,
   output logic                          rsp_table_overflow,
   input  logic                          csr_wr_en,
   input  logic [pctd_pkg::COUNT_W-1:0]  csr_wr_data
);

   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int FREE_W = $clog2(MAX_NODES + 1);
   localparam int WORD_W = 2 * NODE_W + pctd_pkg::SYMBOL_W;
   localparam int SYM_W  = pctd_pkg::SYMBOL_W;
   localparam int CNT_W  = pctd_pkg::COUNT_W;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_LD_EVAL = 5'b00010,
      ST_LD_LINK = 5'b00100,
      ST_DC_EVAL = 5'b01000,
      ST_DC_FIN  = 5'b10000
   } state_type;

   state_type                          state_ff, state_in;
   logic [NODE_W-1:0]                  cur_node_ff, cur_node_in;
   logic [NODE_W-1:0]                  ld_node_ff, ld_node_in;
   logic [FREE_W-1:0]                  nfree_ff, nfree_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic [CNT_W-1:0]                   total_ff, total_in;
   logic                               ovf_ff, ovf_in;
   logic [NODE_W-1:0]                  root_left_ff, root_left_in;
   logic [NODE_W-1:0]                  root_right_ff, root_right_in;
   logic [SYM_W-1:0]                   root_sym_ff, root_sym_in;
   logic [pctd_pkg::BYTE_W-1:0]        byte_ff, byte_in;
   logic [pctd_pkg::BIT_CNT_W-1:0]     bits_left_ff, bits_left_in;
   logic [pctd_pkg::CODE_W-1:0]        word_ff, word_in;
   logic [pctd_pkg::LENGTH_W-1:0]      len_ff, len_in;
   logic [SYM_W-1:0]                   sym_ff, sym_in;

   logic                               mem_wr_en;
   logic [NODE_W-1:0]                  mem_wr_addr;
   logic [WORD_W-1:0]                  mem_wr_data;
   logic                               mem_rd_en;
   logic [NODE_W-1:0]                  mem_rd_addr;
   logic [WORD_W-1:0]                  mem_rd_data;

   pctd_pkg::push_type                 push;
   logic                               push_ok;

   logic                               req_accept;
   logic                               in_load;
   logic [NODE_W-1:0]                  walk_node;
   logic [NODE_W-1:0]                  node_left;
   logic [NODE_W-1:0]                  node_right;
   logic [SYM_W-1:0]                   node_sym;
   logic [pctd_pkg::CODE_IDX_W-1:0]    ld_bit_idx;
   logic                               step_bit;
   logic [NODE_W-1:0]                  child;
   logic [NODE_W-1:0]                  fresh;
   logic [CNT_W:0]                     count_next;
   logic                               hit;

   pctd_node_mem #(
      .MAX_NODES (MAX_NODES)
   ) u_node_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pctd_rsp_buf u_rsp_buf (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .push_ok            (push_ok),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_symbol     (rsp_out_symbol),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_stream_done    (rsp_stream_done),
      .rsp_table_overflow (rsp_table_overflow)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // The root lives in flip-flops; every other node's word is the registered read data,
   // which always belongs to the node that the active walk points at.
   always_comb begin
      in_load    = (state_ff == ST_LD_EVAL) || (state_ff == ST_LD_LINK);
      walk_node  = in_load ? ld_node_ff : cur_node_ff;
      if (walk_node == '0) begin
         node_left  = root_left_ff;
         node_right = root_right_ff;
         node_sym   = root_sym_ff;
      end else begin
         node_left  = mem_rd_data[WORD_W-1 -: NODE_W];
         node_right = mem_rd_data[SYM_W +: NODE_W];
         node_sym   = mem_rd_data[SYM_W-1:0];
      end
      ld_bit_idx = pctd_pkg::CODE_IDX_W'(len_ff - pctd_pkg::LENGTH_W'(1));
      step_bit   = in_load ? word_ff[ld_bit_idx] : byte_ff[pctd_pkg::BYTE_W-1];
      child      = step_bit ? node_left : node_right;
      fresh      = nfree_ff[NODE_W-1:0];
      count_next = {1'b0, count_ff} + (CNT_W+1)'(1);
      hit        = count_next >= {1'b0, total_ff};
   end

   always_comb begin
      state_in      = state_ff;
      cur_node_in   = cur_node_ff;
      ld_node_in    = ld_node_ff;
      nfree_in      = nfree_ff;
      count_in      = count_ff;
      total_in      = csr_wr_en ? csr_wr_data : total_ff;
      ovf_in        = ovf_ff;
      root_left_in  = root_left_ff;
      root_right_in = root_right_ff;
      root_sym_in   = root_sym_ff;
      byte_in       = byte_ff;
      bits_left_in  = bits_left_ff;
      word_in       = word_ff;
      len_in        = len_ff;
      sym_in        = sym_ff;

      mem_wr_en   = 1'b0;
      mem_wr_addr = walk_node;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = child;

      push.emit     = 1'b0;
      push.flush    = 1'b0;
      push.symbol   = node_sym;
      push.done     = hit;
      push.overflow = ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            // Keep the decode walk's node word fresh for the next byte.
            mem_rd_en   = 1'b1;
            mem_rd_addr = cur_node_ff;
            if (req_accept) begin
               case (pctd_pkg::op_type'(req_operation))
                  pctd_pkg::OP_CLEAR: begin
                     root_left_in  = '0;
                     root_right_in = '0;
                     root_sym_in   = '0;
                     nfree_in      = FREE_W'(1);
                     cur_node_in   = '0;
                     count_in      = '0;
                     ovf_in        = 1'b0;
                  end
                  pctd_pkg::OP_LOAD: begin
                     ld_node_in = '0;
                     word_in    = req_code_word;
                     sym_in     = req_code_symbol;
                     if (req_code_length > pctd_pkg::LENGTH_W'(pctd_pkg::CODE_W)) begin
                        len_in = pctd_pkg::LENGTH_W'(pctd_pkg::CODE_W);
                     end else begin
                        len_in = req_code_length;
                     end
                     state_in = ST_LD_EVAL;
                  end
                  pctd_pkg::OP_DECODE: begin
                     if (count_ff < total_ff) begin
                        byte_in      = req_data_byte;
                        bits_left_in = pctd_pkg::BIT_CNT_W'(pctd_pkg::BYTE_W);
                        state_in     = ST_DC_EVAL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_LD_EVAL: begin
            if (len_ff == '0) begin
               if (ld_node_ff == '0) begin
                  root_sym_in = sym_ff;
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = {node_left, node_right, sym_ff};
               end
               state_in = ST_IDLE;
            end else if (child != '0) begin
               ld_node_in = child;
               mem_rd_en  = 1'b1;
               len_in     = len_ff - pctd_pkg::LENGTH_W'(1);
            end else if (nfree_ff == FREE_W'(MAX_NODES)) begin
               // Store full: the entry is dropped, nodes already made for it remain.
               ovf_in   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = fresh;
               mem_wr_data = '0;
               state_in    = ST_LD_LINK;
            end
         end

         ST_LD_LINK: begin
            if (ld_node_ff == '0) begin
               if (step_bit) begin
                  root_left_in = fresh;
               end else begin
                  root_right_in = fresh;
               end
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_data = step_bit ? {fresh, node_right, node_sym}
                                      : {node_left, fresh, node_sym};
            end
            nfree_in    = nfree_ff + FREE_W'(1);
            ld_node_in  = fresh;
            mem_rd_en   = 1'b1;
            mem_rd_addr = fresh;
            len_in      = len_ff - pctd_pkg::LENGTH_W'(1);
            state_in    = ST_LD_EVAL;
         end

         ST_DC_EVAL: begin
            if (bits_left_ff != '0) begin
               if (child != '0) begin
                  cur_node_in  = child;
                  mem_rd_en    = 1'b1;
                  byte_in      = {byte_ff[pctd_pkg::BYTE_W-2:0], 1'b0};
                  bits_left_in = bits_left_ff - pctd_pkg::BIT_CNT_W'(1);
               end else if (cur_node_ff == '0) begin
                  // No code starts with this bit: drop it.
                  byte_in      = {byte_ff[pctd_pkg::BYTE_W-2:0], 1'b0};
                  bits_left_in = bits_left_ff - pctd_pkg::BIT_CNT_W'(1);
               end else begin
                  // Leaf reached: emit, then retry the same bit from the root.
                  push.emit = 1'b1;
                  if (push_ok) begin
                     count_in    = count_next[CNT_W-1:0];
                     cur_node_in = '0;
                     if (hit) begin
                        state_in = ST_DC_FIN;
                     end
                  end
               end
            end else if (cur_node_ff != '0 && node_left == '0 && node_right == '0) begin
               push.emit = 1'b1;
               if (push_ok) begin
                  count_in    = count_next[CNT_W-1:0];
                  cur_node_in = '0;
                  state_in    = ST_DC_FIN;
               end
            end else begin
               state_in = ST_DC_FIN;
            end
         end

         ST_DC_FIN: begin
            push.flush = 1'b1;
            if (push_ok) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_node_ff   <= '0;
         ld_node_ff    <= '0;
         nfree_ff      <= FREE_W'(1);
         count_ff      <= '0;
         total_ff      <= '0;
         ovf_ff        <= 1'b0;
         root_left_ff  <= '0;
         root_right_ff <= '0;
         root_sym_ff   <= '0;
         bits_left_ff  <= '0;
         len_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         cur_node_ff   <= cur_node_in;
         ld_node_ff    <= ld_node_in;
         nfree_ff      <= nfree_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         ovf_ff        <= ovf_in;
         root_left_ff  <= root_left_in;
         root_right_ff <= root_right_in;
         root_sym_ff   <= root_sym_in;
         bits_left_ff  <= bits_left_in;
         len_ff        <= len_in;
      end
      byte_ff <= byte_in;
      word_ff <= word_in;
      sym_ff  <= sym_in;
   end

   a_free_range: assert property (@(posedge clock) disable iff (reset)
      (nfree_ff >= FREE_W'(1)) && (nfree_ff <= FREE_W'(MAX_NODES)))
      else $error("free-node counter out of range");

   a_walk_allocated: assert property (@(posedge clock) disable iff (reset)
      FREE_W'(cur_node_ff) < nfree_ff)
      else $error("decode walk points at an unallocated node");

   a_total_reached_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_operation == pctd_pkg::OP_DECODE && count_ff >= total_ff)
      |=> (state_ff == ST_IDLE))
      else $error("decode transaction started after the total was reached");

   a_no_push_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!push.emit && !push.flush))
      else $error("result pushed while the walker is idle");

endmodule
